// File: rtl/tdem_pkg.sv
package tdem_pkg;

  localparam int unsigned LogTableBits = 8;
  localparam int unsigned LogTabSize   = 1 << LogTableBits;

  localparam logic [2:0] RegThreshold = 3'd0;
  localparam logic [2:0] RegGain      = 3'd1;
  localparam logic [2:0] RegInner     = 3'd2;
  localparam logic [2:0] RegOuter     = 3'd3;
  localparam logic [2:0] RegAxisDz    = 3'd4;
  localparam logic [2:0] RegSensExp   = 3'd5;
  localparam logic [2:0] RegAxisSel   = 3'd6;

  localparam logic [1:0] KindPressed  = 2'd0;
  localparam logic [1:0] KindHeld     = 2'd1;
  localparam logic [1:0] KindReleased = 2'd2;

  typedef enum logic {
    ArDiv,
    ArSqrt
  } arith_op_e;

  typedef logic [15:0] log_tab_t [LogTabSize];
  typedef logic [31:0] exp_tab_t [LogTabSize];

  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bitv;
    n    = n_in;
    res  = '0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] log_entry(input int unsigned idx);
    logic [63:0] y;
    logic [15:0] res;
    y   = (64'd1 << 30) + (64'(idx) << (30 - LogTableBits));
    res = '0;
    for (int b = 15; b >= 0; b--) begin
      y = (y * y) >> 30;
      if (y >= (64'd1 << 31)) begin
        y      = y >> 1;
        res[b] = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic logic [31:0] exp_entry(input int unsigned idx);
    logic [63:0] v;
    logic [63:0] r;
    v = 64'd1 << 30;
    r = isqrt64(64'd1 << 61);
    for (int j = 1; j <= LogTableBits; j++) begin
      if (((idx >> (LogTableBits - j)) & 1) != 0) begin
        v = (v * r) >> 30;
      end
      r = isqrt64(r << 30);
    end
    return v[31:0];
  endfunction

  function automatic log_tab_t build_log_tab();
    log_tab_t t;
    for (int i = 0; i < LogTabSize; i++) begin
      t[i] = log_entry(i);
    end
    return t;
  endfunction

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t t;
    for (int i = 0; i < LogTabSize; i++) begin
      t[i] = exp_entry(i);
    end
    return t;
  endfunction

  localparam log_tab_t LogTab = build_log_tab();
  localparam exp_tab_t ExpTab = build_exp_tab();

endpackage

// File: rtl/tdem_arith.sv
module tdem_arith (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  tdem_pkg::arith_op_e mode_i,
  input  logic [31:0]         a_i,
  input  logic [16:0]         b_i,
  output logic                done_o,
  output logic [31:0]         res_o
);
  import tdem_pkg::*;

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  arith_op_e   mode_q;
  logic [31:0] x_q, x_d;
  logic [31:0] r_q, r_d;
  logic [31:0] bit_q;
  logic [16:0] b_q;
  logic [17:0] rem_sh;
  logic        ge;
  logic [31:0] t;

  always_comb begin
    rem_sh = {r_q[16:0], x_q[31]};
    ge     = rem_sh >= {1'b0, b_q};
    t      = r_q + bit_q;
    if (mode_q == ArDiv) begin
      r_d = ge ? {14'd0, rem_sh - {1'b0, b_q}} : {14'd0, rem_sh};
      x_d = {x_q[30:0], ge};
    end else if (x_q >= t) begin
      x_d = x_q - t;
      r_d = (r_q >> 1) + bit_q;
    end else begin
      x_d = x_q;
      r_d = r_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= (mode_i == ArDiv) ? 5'd31 : 5'd15;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mode_q <= mode_i;
      x_q    <= a_i;
      r_q    <= '0;
      b_q    <= b_i;
      bit_q  <= 32'd1 << 30;
    end else if (busy_q) begin
      x_q   <= x_d;
      r_q   <= r_d;
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign res_o  = (mode_q == ArDiv) ? x_q : r_q;

endmodule

// File: rtl/thumbstick_deadzone_event_mapper_unit.sv
// Channel  | Dir | Fields (lowest bit up)
// s_axis   | in  | tdata: stick_x, stick_y, source_device, user_id; tuser: op, has_axis_data
// m_axis   | out | tdata: event_value, event_user; tuser: event_kind
// cfg      | in  | cfg_we_i, cfg_idx_i, cfg_data_i
// A sample with axis data runs two square roots and six divides on the shared
// arith unit plus single steps; a saturated divide skips the unit, and a zero
// shaped length skips the power steps and the output divide.
// A stop, a zero or dataless sample goes straight to scale and emit; a foreign sample is dropped.
// Reset clears the press and owner state and loads register defaults.
// The next word is taken while a result waits; emit holds while that register is stalled.
module thumbstick_deadzone_event_mapper_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // stick_x, stick_y, source_device, user_id
  input  logic [1:0]  s_axis_tuser,   // op, has_axis_data
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // event_value, event_user, zero pad
  output logic [1:0]  m_axis_tuser,   // event_kind
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import tdem_pkg::*;

  typedef enum logic [20:0] {
    StIdle  = 21'h000001,
    StMsqx  = 21'h000002,
    StMsqy  = 21'h000004,
    StSq1   = 21'h000008,
    StPc    = 21'h000010,
    StMcx   = 21'h000020,
    StDcx   = 21'h000040,
    StMcy   = 21'h000080,
    StDcy   = 21'h000100,
    StGx    = 21'h000200,
    StGy    = 21'h000400,
    StM2x   = 21'h000800,
    StM2y   = 21'h001000,
    StSq2   = 21'h002000,
    StPow1  = 21'h004000,
    StPow2  = 21'h008000,
    StPow3  = 21'h010000,
    StMout  = 21'h020000,
    StDout  = 21'h040000,
    StScale = 21'h080000,
    StEmit  = 21'h100000
  } state_e;

  state_e state_q, state_d;

  logic [15:0] thr_q, inner_q, outer_q, adz_q, sexp_q;
  logic signed [15:0] gain_q;
  logic        asel_q;
  logic        was_pressed_q, owner_valid_q;
  logic [3:0]  owner_dev_q;

  logic [16:0] ax_q, ay_q;
  logic        negsel_q, stop_q;
  logic [3:0]  dev_q, user_q;
  logic [15:0] len_q, pc_q, cx_q, cy_q, mx_q, my_q, l2_q, p_q;
  logic [19:0] neg_q;
  logic [16:0] mag_q;
  logic [36:0] mul_q;
  logic        pend_q;

  logic        out_valid_q;
  logic [23:0] out_value_q;
  logic [3:0]  out_user_q;
  logic [1:0]  out_kind_q;

  logic        in_acc, out_free;
  logic signed [15:0] in_x, in_y;
  logic [16:0] in_ax, in_ay;

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_x          = s_axis_tdata[15:0];
  assign in_y          = s_axis_tdata[31:16];
  assign in_ax         = in_x[15] ? 17'(-{in_x[15], in_x}) : {1'b0, in_x};
  assign in_ay         = in_y[15] ? 17'(-{in_y[15], in_y}) : {1'b0, in_y};
  assign out_free      = !out_valid_q || m_axis_tready;

  // saturating divide operands
  logic signed [17:0] pnum, pden, gnum, gden;
  logic [16:0] cur_abs;
  logic        pskip, gskip;
  assign cur_abs = (state_q == StGx) ? ax_q : ay_q;
  assign pnum    = $signed({2'b0, len_q}) - $signed({2'b0, inner_q});
  assign pden    = $signed({2'b0, outer_q}) - $signed({2'b0, inner_q});
  assign gnum    = $signed({1'b0, cur_abs}) - $signed({2'b0, adz_q});
  assign gden    = $signed({2'b0, outer_q}) - $signed({2'b0, adz_q});
  assign pskip   = pnum[17] || (pnum == '0) || pden[17] || (pden == '0);
  assign gskip   = gnum[17] || (gnum == '0) || gden[17] || (gden == '0);

  // shared arith unit
  logic        ar_start, ar_done, is_ar, skip;
  arith_op_e   ar_mode;
  logic [31:0] ar_a, ar_res;
  logic [16:0] ar_b;
  logic [15:0] ar_cap, gval;

  always_comb begin
    is_ar   = 1'b1;
    skip    = 1'b0;
    ar_mode = ArDiv;
    ar_a    = mul_q[31:0];
    ar_b    = {1'b0, len_q};
    unique case (state_q)
      StSq1, StSq2: ar_mode = ArSqrt;
      StPc: begin
        skip = pskip;
        ar_a = {1'b0, pnum[15:0], 15'd0};
        ar_b = pden[16:0];
      end
      StDcx, StDcy: ar_b = {1'b0, len_q};
      StGx, StGy: begin
        skip = gskip;
        ar_a = {1'b0, gnum[15:0], 15'd0};
        ar_b = gden[16:0];
      end
      StDout: ar_b = {1'b0, l2_q};
      default: is_ar = 1'b0;
    endcase
  end

  assign ar_start = is_ar && !pend_q && !skip;
  assign ar_cap   = (ar_res > 32'd32768) ? 16'h8000 : ar_res[15:0];
  assign gval     = gskip ? ((gnum[17] || gnum == '0) ? 16'd0 : 16'h8000) : ar_cap;

  tdem_arith u_arith (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ar_start),
    .mode_i  (ar_mode),
    .a_i     (ar_a),
    .b_i     (ar_b),
    .done_o  (ar_done),
    .res_o   (ar_res)
  );

  // shared multiplier
  logic [19:0] mul_a;
  logic [16:0] mul_b;
  logic [36:0] mul_p;
  logic        mul_acc;
  logic [15:0] gain_abs;
  assign gain_abs = gain_q[15] ? 16'(-gain_q) : gain_q;

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_acc = 1'b0;
    case (state_q)
      StMsqx: begin mul_a = {3'd0, ax_q}; mul_b = ax_q; end
      StMsqy: begin mul_a = {3'd0, ay_q}; mul_b = ay_q; mul_acc = 1'b1; end
      StMcx:  begin mul_a = {3'd0, ax_q}; mul_b = {1'b0, pc_q}; end
      StMcy:  begin mul_a = {3'd0, ay_q}; mul_b = {1'b0, pc_q}; end
      StM2x:  begin mul_a = {4'd0, mx_q}; mul_b = {1'b0, mx_q}; end
      StM2y:  begin mul_a = {4'd0, my_q}; mul_b = {1'b0, my_q}; mul_acc = 1'b1; end
      StPow2: begin mul_a = neg_q; mul_b = {1'b0, sexp_q}; end
      StMout: begin mul_a = {4'd0, asel_q ? my_q : mx_q}; mul_b = {1'b0, p_q}; end
      StScale: begin mul_a = {3'd0, mag_q}; mul_b = {1'b0, gain_abs}; end
      default: ;
    endcase
    mul_p = ({17'd0, mul_a} * {20'd0, mul_b}) + (mul_acc ? mul_q : 37'd0);
  end

  // power: log stage
  logic [3:0]  lz;
  logic [15:0] norm, lt;
  logic [20:0] negw;
  always_comb begin
    lz = '0;
    for (int i = 0; i < 16; i++) begin
      if (pc_q[i]) lz = 4'(15 - i);
    end
    norm = pc_q << lz;
    lt   = LogTab[norm[14 -: LogTableBits]];
    negw = {1'b0, lz, 16'd0} - {5'd0, lt};
  end

  // power: exp stage
  logic [8:0]  pq;
  logic [15:0] pr, pg;
  logic [9:0]  ps;
  logic        pzero;
  logic [16:0] pe;
  logic [16:0] pv;
  always_comb begin
    pq    = mul_q[36:28];
    pr    = mul_q[27:12];
    ps    = (pr == '0) ? {1'b0, pq} : ({1'b0, pq} + 10'd1);
    pzero = (pq > 9'd64) || (ps > 10'd31);
    pg    = 16'd0 - pr;
    pe    = 17'(ExpTab[pg[15 -: LogTableBits]] >> 15);
    pv    = pe >> ps[4:0];
  end

  // result
  logic        pressed, emit, vsign;
  logic [25:0] vsh;
  logic [23:0] vout;
  logic [1:0]  kind;
  always_comb begin
    pressed = !stop_q && (mag_q > {1'b0, thr_q});
    emit    = stop_q ? was_pressed_q : (pressed || was_pressed_q);
    kind    = (stop_q || !pressed) ? KindReleased :
              (was_pressed_q ? KindHeld : KindPressed);
    vsign   = negsel_q ^ gain_q[15];
    vsh     = 26'((mul_q[32:0] + (vsign ? 33'd255 : 33'd0)) >> 8);
    vout    = vsign ? 24'(-vsh[23:0]) : vsh[23:0];
  end

  // sequencer
  logic adv;
  always_comb begin
    state_d = state_q;
    adv     = !is_ar || skip || ar_done;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (s_axis_tuser[0]) state_d = StScale;
          else if (owner_valid_q && s_axis_tdata[35:32] != owner_dev_q) state_d = StIdle;
          else if (!s_axis_tuser[1] || (in_x == '0 && in_y == '0)) state_d = StScale;
          else state_d = StMsqx;
        end
      end
      StMsqx: state_d = StMsqy;
      StMsqy: state_d = StSq1;
      StSq1:  if (adv) state_d = StPc;
      StPc:   if (adv) state_d = StMcx;
      StMcx:  state_d = StDcx;
      StDcx:  if (adv) state_d = StMcy;
      StMcy:  state_d = StDcy;
      StDcy:  if (adv) state_d = StGx;
      StGx:   if (adv) state_d = StGy;
      StGy:   if (adv) state_d = StM2x;
      StM2x:  state_d = StM2y;
      StM2y:  state_d = StSq2;
      StSq2:  if (adv) state_d = (ar_res == '0) ? StScale : StPow1;
      StPow1: state_d = StPow2;
      StPow2: state_d = StPow3;
      StPow3: state_d = StMout;
      StMout: state_d = StDout;
      StDout: if (adv) state_d = StScale;
      StScale: state_d = StEmit;
      StEmit: if (!emit || out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      pend_q        <= 1'b0;
      thr_q         <= 16'd0;
      gain_q        <= 16'sd256;
      inner_q       <= 16'd0;
      outer_q       <= 16'h8000;
      adz_q         <= 16'd0;
      sexp_q        <= 16'd4096;
      asel_q        <= 1'b0;
      was_pressed_q <= 1'b0;
      owner_valid_q <= 1'b0;
      owner_dev_q   <= 4'd0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ar_start) pend_q <= 1'b1;
      else if (ar_done) pend_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegThreshold: thr_q   <= cfg_data_i;
          RegGain:      gain_q  <= cfg_data_i;
          RegInner:     inner_q <= cfg_data_i;
          RegOuter:     outer_q <= cfg_data_i;
          RegAxisDz:    adz_q   <= cfg_data_i;
          RegSensExp:   sexp_q  <= cfg_data_i;
          RegAxisSel:   asel_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (state_q == StEmit && emit && out_free) out_valid_q <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) out_valid_q <= 1'b0;
      if (state_q == StEmit && (!emit || out_free)) begin
        was_pressed_q <= pressed;
        owner_valid_q <= pressed;
        owner_dev_q   <= pressed ? dev_q : 4'd0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ax_q     <= in_ax;
      ay_q     <= in_ay;
      negsel_q <= asel_q ? in_y[15] : in_x[15];
      dev_q    <= s_axis_tdata[35:32];
      user_q   <= s_axis_tdata[39:36];
      stop_q   <= s_axis_tuser[0];
      mag_q    <= '0;
    end
    if (state_q != StEmit) mul_q <= mul_p;
    if (adv) begin
      case (state_q)
        StSq1: len_q <= ar_res[15:0];
        StPc:  pc_q <= pskip ? ((pnum[17] || pnum == '0) ? 16'd0 : 16'h8000) : ar_cap;
        StDcx: cx_q <= ar_res[15:0];
        StDcy: cy_q <= ar_res[15:0];
        StGx:  mx_q <= (cx_q < gval) ? cx_q : gval;
        StGy:  my_q <= (cy_q < gval) ? cy_q : gval;
        StSq2: l2_q <= ar_res[15:0];
        StDout: mag_q <= ar_res[16:0];
        default: ;
      endcase
    end
    if (state_q == StPow1) neg_q <= negw[20] ? 20'd0 : negw[19:0];
    if (state_q == StPow3) p_q <= pzero ? 16'd0 : pv[15:0];
    if (state_q == StEmit && emit && out_free) begin
      out_value_q <= vout;
      out_user_q  <= user_q;
      out_kind_q  <= kind;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_user_q, out_value_q};
  assign m_axis_tuser  = out_kind_q;

endmodule

// File: test/thumbstick_deadzone_event_mapper_unit_tb.sv
`timescale 1ns / 1ps

module thumbstick_deadzone_event_mapper_unit_tb;
  import tdem_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [23:0] value;
    logic [3:0]  user;
  } stick_event_t;

  typedef struct {
    logic        op;
    logic [15:0] sx;
    logic [15:0] sy;
    logic        has;
    logic [3:0]  dev;
    logic [3:0]  user;
    logic        chk;
    logic [1:0]  kind;
    logic [23:0] value;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  thumbstick_deadzone_event_mapper_unit dut (.*);

  always #1 clk_i = ~clk_i;

  logic [15:0] thr_q, inner_q, outer_q, adz_q, exp_q;
  logic signed [15:0] gain_q;
  logic axsel_q;
  logic pressed_q, owner_vld_q;
  logic [3:0] owner_dev_q;

  logic [15:0] ln_tab [256];
  logic [31:0] ex_tab [256];

  stick_event_t pending_events[$];
  int errors = 0;
  int send_idle = 30, recv_idle = 50;
  stim_row_t drow[$];

  function automatic logic [63:0] root64(logic [63:0] n_in);
    logic [63:0] n, res, b;
    n = n_in; res = 0; b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  task automatic fill_tables();
    logic [63:0] y, v, r;
    logic [15:0] acc;
    for (int i = 0; i < 256; i++) begin
      y = (64'd1 << 30) + (64'(i) << 22);
      acc = 0;
      for (int b = 15; b >= 0; b--) begin
        y = (y * y) >> 30;
        if (y >= (64'd1 << 31)) begin
          y = y >> 1;
          acc[b] = 1'b1;
        end
      end
      ln_tab[i] = acc;
      v = 64'd1 << 30;
      r = root64(64'd1 << 61);
      for (int j = 1; j <= 8; j++) begin
        if ((i >> (8 - j)) & 1) v = (v * r) >> 30;
        r = root64(r << 30);
      end
      ex_tab[i] = v[31:0];
    end
  endtask

  function automatic logic [31:0] curve_pow(logic [31:0] pc, logic [31:0] e);
    int k;
    logic [31:0] n, idx, q, r, s, g;
    longint neg;
    logic [63:0] a;
    k = 15;
    while (k > 0 && pc[k] == 1'b0) k--;
    n = (pc << (15 - k)) & 32'hFFFF;
    idx = ((n - 32768) & 32'h7FFF) >> 7;
    neg = longint'(15 - k) * 65536 - longint'(ln_tab[idx]);
    if (neg < 0) neg = 0;
    a = (64'(neg) * 64'(e)) >> 12;
    q = a[47:16];
    r = {16'd0, a[15:0]};
    if ((a >> 16) > 64) return 0;
    if (r == 0) begin
      s = q; g = 0;
    end else begin
      s = q + 1; g = 65536 - r;
    end
    if (s > 31) return 0;
    return 32'(64'(ex_tab[g >> 8]) >> (15 + s));
  endfunction

  function automatic logic [31:0] clamp_div(longint num, longint den);
    logic [63:0] qv;
    if (num <= 0) return 0;
    if (den <= 0) return 32768;
    qv = (64'(num) << 15) / 64'(den);
    return qv > 32768 ? 32'd32768 : qv[31:0];
  endfunction

  function automatic int shaped_axis(logic signed [15:0] x, logic signed [15:0] y);
    logic [31:0] ax, ay, len, pc, cx, cy, gx, gy, mx, my, l2, p, o;
    logic neg;
    ax = x < 0 ? -int'(x) : int'(x);
    ay = y < 0 ? -int'(y) : int'(y);
    if (ax == 0 && ay == 0) return 0;
    len = 32'(root64(64'(ax) * ax + 64'(ay) * ay));
    pc = clamp_div(longint'(len) - inner_q, longint'(outer_q) - inner_q);
    cx = 32'((64'(ax) * pc) / len);
    cy = 32'((64'(ay) * pc) / len);
    gx = clamp_div(longint'(ax) - adz_q, longint'(outer_q) - adz_q);
    gy = clamp_div(longint'(ay) - adz_q, longint'(outer_q) - adz_q);
    mx = cx < gx ? cx : gx;
    my = cy < gy ? cy : gy;
    l2 = 32'(root64(64'(mx) * mx + 64'(my) * my));
    if (l2 == 0) return 0;
    p = curve_pow(pc, exp_q);
    if (axsel_q) begin
      o = 32'((64'(my) * p) / l2); neg = y < 0;
    end else begin
      o = 32'((64'(mx) * p) / l2); neg = x < 0;
    end
    return neg ? -int'(o) : int'(o);
  endfunction

  function automatic logic [23:0] apply_gain(int v);
    longint prod, res;
    prod = longint'(v) * gain_q;
    if (prod < 0) res = -(((-prod) + 255) >>> 8);
    else res = prod >>> 8;
    return res[23:0];
  endfunction

  function automatic bit map_sample(logic op, logic [15:0] sx, logic [15:0] sy,
                                    logic has, logic [3:0] dev, logic [3:0] user,
                                    output stick_event_t ev);
    int v;
    logic [31:0] mag;
    logic hit;
    bit got;
    got = 0;
    ev = '0;
    if (op) begin
      if (pressed_q) begin
        ev = '{KindReleased, 24'd0, user};
        got = 1;
      end
      pressed_q = 0; owner_vld_q = 0; owner_dev_q = 0;
      return got;
    end
    if (owner_vld_q && dev != owner_dev_q) return 0;
    v = has ? shaped_axis(sx, sy) : 0;
    mag = v < 0 ? -v : v;
    hit = mag > thr_q;
    if (hit || pressed_q) begin
      ev.kind = hit ? (pressed_q ? KindHeld : KindPressed) : KindReleased;
      ev.value = apply_gain(v);
      ev.user = user;
      got = 1;
    end
    pressed_q = hit; owner_vld_q = hit; owner_dev_q = hit ? dev : 0;
    return got;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegThreshold: thr_q = val;
      RegGain:      gain_q = val;
      RegInner:     inner_q = val;
      RegOuter:     outer_q = val;
      RegAxisDz:    adz_q = val;
      RegSensExp:   exp_q = val;
      RegAxisSel:   axsel_q = val[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic drain_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic send_word(logic op, logic [15:0] sx, logic [15:0] sy, logic has,
                           logic [3:0] dev, logic [3:0] user);
    stick_event_t ev;
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {user, dev, sy, sx};
    s_axis_tuser <= {has, op};
    do @(posedge clk_i); while (!s_axis_tready);
    if (map_sample(op, sx, sy, has, dev, user, ev))
      pending_events.insert(pending_events.size(), ev);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    stick_event_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_events.size() == 0) begin
        report_mismatch("unexpected word", m_axis_tdata, 32'd0);
      end else begin
        want = pending_events.pop_front();
        if (m_axis_tuser !== want.kind)
          report_mismatch("kind", 32'(m_axis_tuser), 32'(want.kind));
        if (m_axis_tdata[23:0] !== want.value)
          report_mismatch("value", 32'(m_axis_tdata[23:0]), 32'(want.value));
        if (m_axis_tdata[27:24] !== want.user)
          report_mismatch("user", 32'(m_axis_tdata[27:24]), 32'(want.user));
      end
    end
  end

  task automatic rand_phase(int count);
    logic [15:0] sx, sy;
    logic [3:0] dev;
    for (int i = 0; i < count; i++) begin
      dev = $urandom_range(99) < 80 ? 4'd3 : 4'($urandom);
      case ($urandom_range(5))
        0: begin sx = 16'($urandom); sy = 16'($urandom); end
        1: begin sx = 16'($urandom_range(2000)); sy = 16'($urandom); end
        2: begin sx = 16'h8000; sy = 16'($urandom_range(1)) ? 16'h7FFF : 16'h8000; end
        default: begin
          sx = 16'(int'($urandom_range(65535)) - 32768);
          sy = 16'($urandom_range(4000)) - 16'd2000;
        end
      endcase
      send_word($urandom_range(99) < 6, sx, sy, $urandom_range(99) < 90, dev,
                4'($urandom));
    end
  endtask

  task automatic add_row(logic op, logic [15:0] sx, logic [15:0] sy, logic has,
                         logic [3:0] dev, logic [3:0] user, logic chk,
                         logic [1:0] kind, logic [23:0] value);
    drow.insert(drow.size(), '{op, sx, sy, has, dev, user, chk, kind, value});
  endtask

  initial begin
    stick_event_t ev;
    fill_tables();
    thr_q = 0; gain_q = 256; inner_q = 0; outer_q = 32768; adz_q = 0;
    exp_q = 4096; axsel_q = 0; pressed_q = 0; owner_vld_q = 0; owner_dev_q = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(1, 0, 0, 1, 1, 2, 1'b0, 0, 0);
    add_row(0, 0, 0, 1, 1, 2, 1'b0, 0, 0);
    add_row(0, 16'h7FFF, 0, 1, 1, 5, 1'b0, 0, 0);
    add_row(0, 16'h8000, 0, 1, 1, 5, 1'b0, 0, 0);
    add_row(0, 16'h1000, 16'h7FFF, 1, 9, 6, 1'b0, 0, 0);
    add_row(0, 16'h8000, 16'h8000, 1, 1, 7, 1'b0, 0, 0);
    add_row(0, 16'h7FFF, 16'h7FFF, 0, 1, 8, 1'b1, KindReleased, 0);
    add_row(0, 16'h4000, 16'h0100, 1, 15, 0, 1'b0, 0, 0);
    add_row(1, 0, 0, 0, 0, 15, 1'b1, KindReleased, 0);
    add_row(1, 0, 0, 0, 0, 15, 1'b0, 0, 0);
    add_row(0, 16'hC000, 16'h2000, 1, 0, 3, 1'b0, 0, 0);
    add_row(0, 16'h0001, 16'hFFFF, 1, 0, 3, 1'b0, 0, 0);
    foreach (drow[i]) begin
      send_word(drow[i].op, drow[i].sx, drow[i].sy, drow[i].has, drow[i].dev,
                drow[i].user);
      if (drow[i].chk) begin
        ev = pending_events[$];
        if (ev.kind !== drow[i].kind || ev.value !== drow[i].value)
          report_mismatch("table row", 32'(i), 32'({ev.kind, ev.value}));
      end
    end
    drain_idle();

    rand_phase(250);
    drain_idle();
    write_reg(RegThreshold, 16'd8000);
    write_reg(RegGain, 16'h8000);
    write_reg(RegInner, 16'd4000);
    write_reg(RegOuter, 16'd30000);
    write_reg(RegAxisDz, 16'd2000);
    write_reg(RegSensExp, 16'd8192);
    write_reg(RegAxisSel, 16'd1);
    rand_phase(250);
    drain_idle();
    write_reg(RegThreshold, 16'd32768);
    write_reg(RegGain, 16'h7FFF);
    write_reg(RegInner, 16'd32768);
    write_reg(RegOuter, 16'd0);
    write_reg(RegAxisDz, 16'd32768);
    write_reg(RegSensExp, 16'hFFFF);
    rand_phase(150);
    drain_idle();
    send_idle = 50; recv_idle = 30;
    write_reg(RegThreshold, 16'd0);
    write_reg(RegGain, 16'hFF80);
    write_reg(RegInner, 16'd20000);
    write_reg(RegOuter, 16'd10000);
    write_reg(RegAxisDz, 16'd0);
    write_reg(RegSensExp, 16'd0);
    write_reg(RegAxisSel, 16'd0);
    rand_phase(400);
    drain_idle();
    send_idle = 0; recv_idle = 0;
    write_reg(RegThreshold, 16'd1000);
    write_reg(RegGain, 16'd256);
    write_reg(RegInner, 16'd1500);
    write_reg(RegOuter, 16'd32768);
    write_reg(RegAxisDz, 16'd500);
    write_reg(RegSensExp, 16'd2048);
    rand_phase(400);
    drain_idle();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

endmodule
